>>> hw/rtl/spd_pkg.sv
package spd_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int DELAY_DEPTH    = 32768;

  localparam int INTENSITY_BITS = 7;
  localparam int DELAY_BITS     = 15;
  localparam int RAMP_BITS      = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INTENSITY   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_DELAY  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_DELAY = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP        = 2'd3;

  localparam logic [INTENSITY_BITS-1:0] INTENSITY_RESET   = 7'd0;
  localparam logic [DELAY_BITS-1:0]     LEFT_DELAY_RESET  = 15'd18000;
  localparam logic [DELAY_BITS-1:0]     RIGHT_DELAY_RESET = 15'd12000;
  localparam logic [RAMP_BITS-1:0]      RAMP_RESET        = 16'd2400;
  localparam logic [INTENSITY_BITS-1:0] FULL_INTENSITY    = 7'd100;

  // Smoothed gain is hundredths in unsigned Q7.24, at most 100.0.
  localparam int FRAC_BITS    = 24;
  localparam int GAIN_BITS    = 31;
  localparam int STEP_BITS    = 32;
  localparam int DIV_CNT_BITS = 5;
  localparam int X3_BITS      = 29;
  localparam int FBQ_BITS     = 24;

  // Shared multiplier operand widths.
  localparam int MUL_A_BITS = 30;
  localparam int MUL_B_BITS = 31;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  // 0.3 in Q.24, and ceil(2^34 / 25) for an exact divide by 25 of a 29-bit value.
  localparam logic signed [MUL_B_BITS-1:0] COEF_POINT3 = 31'sd5033165;
  localparam logic signed [MUL_B_BITS-1:0] RECIP_25    = 31'sd687194768;
  localparam int RECIP_SHIFT = 34;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] delay_left;
    logic signed [SAMPLE_BITS-1:0] delay_right;
    logic signed [SAMPLE_BITS-1:0] reverb_feed_left;
    logic signed [SAMPLE_BITS-1:0] reverb_feed_right;
  } out_item_t;

endpackage

>>> hw/rtl/stereo_ping_pong_delay.sv
// Channel   Direction  Handshake              Beat payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_ready    in_data (sample_left, sample_right)
// out       out        out_valid / out_ready  out_data (delays, reverb feeds)
//
// The block takes no new beat until it has finished the last one; a change of the
// clamped intensity with a nonzero ramp length adds the bit-serial gain step divide.
// A delay length at or above DELAY_DEPTH is first reduced by repeated subtraction of
// DELAY_DEPTH. All products go through one shared multiplier, five per beat, one per cycle.
// Reset is synchronous; the delay memories need no clearing pass, since a fill flag
// makes entries not yet written read as zero. A stalled result holds the sequencer.
module stereo_ping_pong_delay #(
  parameter int DELAY_DEPTH = spd_pkg::DELAY_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [spd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [spd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  spd_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output spd_pkg::out_item_t                  out_data
);

  localparam int SB   = spd_pkg::SAMPLE_BITS;
  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int DB   = spd_pkg::DELAY_BITS;
  localparam int CW   = ((DB > AW) ? DB : AW) + 1;
  localparam int GW   = spd_pkg::GAIN_BITS;
  localparam int STW  = spd_pkg::STEP_BITS;
  localparam int RW   = spd_pkg::RAMP_BITS;
  localparam int IW   = spd_pkg::INTENSITY_BITS;
  localparam int FB   = spd_pkg::FRAC_BITS;
  localparam int MA   = spd_pkg::MUL_A_BITS;
  localparam int MB   = spd_pkg::MUL_B_BITS;
  localparam int PW   = spd_pkg::PROD_BITS;
  localparam int QW   = spd_pkg::FBQ_BITS;
  localparam int XW   = spd_pkg::X3_BITS;
  localparam int NW   = spd_pkg::DIV_CNT_BITS;

  localparam logic [CW-1:0]        DEPTH_C  = CW'(DELAY_DEPTH);
  localparam logic [AW-1:0]        LAST_POS = AW'(DELAY_DEPTH - 1);
  localparam logic [NW-1:0]        DIV_LAST = NW'(GW - 1);
  localparam logic signed [PW-1:0] HALF_LSB = PW'(64'sd1 <<< (FB - 1));
  localparam logic signed [SB+1:0] SAT_HI   = (SB+2)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SB+1:0] SAT_LO   = -SAT_HI - (SB+2)'(1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_GAIN = 4'd3;
  localparam logic [3:0] S_RED  = 4'd4;
  localparam logic [3:0] S_MFB  = 4'd5;
  localparam logic [3:0] S_M03L = 4'd6;
  localparam logic [3:0] S_M03R = 4'd7;
  localparam logic [3:0] S_MWL  = 4'd8;
  localparam logic [3:0] S_MWR  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]               state;
  logic [IW-1:0]            intensity;
  logic [DB-1:0]            left_delay_samples;
  logic [DB-1:0]            right_delay_samples;
  logic [RW-1:0]            ramp_samples;

  logic signed [SB-1:0]     in_l;
  logic signed [SB-1:0]     in_r;
  logic [GW-1:0]            gain;
  logic signed [STW-1:0]    gain_step;
  logic [RW-1:0]            ramp_remaining;
  logic [IW-1:0]            ramp_target;

  logic [GW-1:0]            div_q;
  logic [RW-1:0]            div_rem;
  logic                     div_neg;
  logic [NW-1:0]            div_cnt;

  logic [DB-1:0]            dl_len;
  logic [DB-1:0]            dr_len;
  logic [AW-1:0]            write_position;
  logic                     wrapped;
  logic signed [SB-1:0]     rd_l_raw;
  logic signed [SB-1:0]     rd_r_raw;
  logic                     rv_l;
  logic                     rv_r;

  logic signed [PW-1:0]     prod;
  logic [QW-1:0]            fbq;
  logic signed [SB-1:0]     fl;
  logic signed [SB-1:0]     fr;

  logic signed [SB-1:0]     mem_l [DELAY_DEPTH];
  logic signed [SB-1:0]     mem_r [DELAY_DEPTH];

  // Gain control.
  logic [IW-1:0]            target;
  logic [GW-1:0]            full_t;
  logic [GW-1:0]            full_rt;
  logic signed [STW-1:0]    diff;
  logic signed [STW-1:0]    diff_neg;
  logic [GW-1:0]            diff_mag;
  logic signed [STW-1:0]    gain_sum;
  logic [RW:0]              rem_sh;
  logic                     div_ge;
  logic [GW-1:0]            q_final;
  logic signed [STW-1:0]    q_signed;
  logic [XW+3:0]            g3;

  // Addressing.
  logic                     l_big;
  logic                     r_big;
  logic [CW-1:0]            sum_l;
  logic [CW-1:0]            sum_r;
  logic [AW-1:0]            ridx_l;
  logic [AW-1:0]            ridx_r;
  logic                     rd_en;

  // Datapath.
  logic signed [SB-1:0]     dl;
  logic signed [SB-1:0]     dr;
  logic signed [MA-1:0]     mul_a;
  logic signed [MB-1:0]     mul_b;
  logic                     mul_en;
  logic signed [PW-1:0]     p_rnd;
  logic signed [SB:0]       rnd;
  logic signed [SB-1:0]     in_sel;
  logic signed [SB+1:0]     acc;
  logic signed [SB-1:0]     sat_res;
  logic                     we_l;
  logic                     fin_go;

  assign in_ready = (state == S_IDLE);

  assign target   = (intensity > spd_pkg::FULL_INTENSITY) ? spd_pkg::FULL_INTENSITY : intensity;
  assign full_t   = GW'(target) << FB;
  assign full_rt  = GW'(ramp_target) << FB;
  assign diff     = $signed({1'b0, full_t}) - $signed({1'b0, gain});
  assign diff_neg = -diff;
  assign diff_mag = diff[STW-1] ? diff_neg[GW-1:0] : diff[GW-1:0];
  assign gain_sum = $signed({1'b0, gain}) + gain_step;

  // Restoring divide, one quotient bit per cycle.
  assign rem_sh   = {div_rem, div_q[GW-1]};
  assign div_ge   = rem_sh >= {1'b0, ramp_samples};
  assign q_final  = {div_q[GW-2:0], div_ge};
  assign q_signed = div_neg ? -$signed({1'b0, q_final}) : $signed({1'b0, q_final});

  // 3g/400 is taken as floor(floor(3g/16) / 25), the last step by reciprocal.
  assign g3 = {2'b00, gain} + {1'b0, gain, 1'b0};

  assign l_big  = CW'(dl_len) >= DEPTH_C;
  assign r_big  = CW'(dr_len) >= DEPTH_C;
  assign sum_l  = CW'(write_position) + DEPTH_C - CW'(dl_len);
  assign sum_r  = CW'(write_position) + DEPTH_C - CW'(dr_len);
  assign ridx_l = (sum_l >= DEPTH_C) ? AW'(sum_l - DEPTH_C) : AW'(sum_l);
  assign ridx_r = (sum_r >= DEPTH_C) ? AW'(sum_r - DEPTH_C) : AW'(sum_r);
  assign rd_en  = (state == S_RED) && !l_big && !r_big;

  // Entries not written since reset read as zero.
  assign dl = rv_l ? rd_l_raw : '0;
  assign dr = rv_r ? rd_r_raw : '0;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state)
      S_MFB: begin
        mul_a = $signed(MA'(g3[XW+3:4]));
        mul_b = spd_pkg::RECIP_25;
      end
      S_M03L: begin
        mul_a = MA'(dl);
        mul_b = spd_pkg::COEF_POINT3;
      end
      S_M03R: begin
        mul_a = MA'(dr);
        mul_b = spd_pkg::COEF_POINT3;
      end
      S_MWL: begin
        mul_a = MA'(dr);
        mul_b = $signed(MB'(fbq));
      end
      S_MWR: begin
        mul_a = MA'(dl);
        mul_b = $signed(MB'(fbq));
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Round half up to Q.24, add the channel input and saturate.
  assign p_rnd   = prod + HALF_LSB;
  assign rnd     = p_rnd[FB+SB:FB];
  assign in_sel  = ((state == S_M03R) || (state == S_MWR)) ? in_l : in_r;
  assign acc     = (SB+2)'(in_sel) + (SB+2)'(rnd);
  assign sat_res = (acc > SAT_HI) ? SAT_HI[SB-1:0] :
                   (acc < SAT_LO) ? SAT_LO[SB-1:0] : acc[SB-1:0];

  assign we_l   = (state == S_MWR);
  assign fin_go = (state == S_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (we_l) begin
      mem_l[write_position] <= sat_res;
    end
    if (rd_en) begin
      rd_l_raw <= mem_l[ridx_l];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      mem_r[write_position] <= sat_res;
    end
    if (rd_en) begin
      rd_r_raw <= mem_r[ridx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity           <= spd_pkg::INTENSITY_RESET;
      left_delay_samples  <= spd_pkg::LEFT_DELAY_RESET;
      right_delay_samples <= spd_pkg::RIGHT_DELAY_RESET;
      ramp_samples        <= spd_pkg::RAMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spd_pkg::REG_INTENSITY:   intensity           <= cfg_data[IW-1:0];
        spd_pkg::REG_LEFT_DELAY:  left_delay_samples  <= cfg_data[DB-1:0];
        spd_pkg::REG_RIGHT_DELAY: right_delay_samples <= cfg_data[DB-1:0];
        spd_pkg::REG_RAMP:        ramp_samples        <= cfg_data[RW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      gain           <= '0;
      gain_step      <= '0;
      ramp_remaining <= '0;
      ramp_target    <= spd_pkg::INTENSITY_RESET;
      write_position <= '0;
      wrapped        <= 1'b0;
      out_valid      <= 1'b0;
      div_cnt        <= '0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            in_l   <= in_data.sample_left;
            in_r   <= in_data.sample_right;
            dl_len <= left_delay_samples;
            dr_len <= right_delay_samples;
            state  <= S_CHK;
          end
        end
        S_CHK: begin
          if (target != ramp_target) begin
            ramp_target <= target;
            if (ramp_samples == '0) begin
              gain           <= full_t;
              ramp_remaining <= '0;
              gain_step      <= '0;
              state          <= S_GAIN;
            end else begin
              ramp_remaining <= ramp_samples;
              div_q          <= diff_mag;
              div_rem        <= '0;
              div_neg        <= diff[STW-1];
              div_cnt        <= '0;
              state          <= S_DIV;
            end
          end else begin
            state <= S_GAIN;
          end
        end
        S_DIV: begin
          div_rem <= div_ge ? RW'(rem_sh - {1'b0, ramp_samples}) : rem_sh[RW-1:0];
          div_q   <= q_final;
          div_cnt <= div_cnt + NW'(1);
          if (div_cnt == DIV_LAST) begin
            gain_step <= q_signed;
            state     <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (ramp_remaining != '0) begin
            ramp_remaining <= ramp_remaining - RW'(1);
            if (ramp_remaining != RW'(1)) begin
              gain <= gain_sum[GW-1:0];
            end else begin
              gain <= full_rt;
            end
          end
          state <= S_RED;
        end
        S_RED: begin
          // Lengths at or above the memory depth wrap around it.
          if (l_big) begin
            dl_len <= DB'(CW'(dl_len) - DEPTH_C);
          end
          if (r_big) begin
            dr_len <= DB'(CW'(dr_len) - DEPTH_C);
          end
          if (rd_en) begin
            rv_l  <= wrapped || (ridx_l < write_position);
            rv_r  <= wrapped || (ridx_r < write_position);
            state <= S_MFB;
          end
        end
        S_MFB: begin
          state <= S_M03L;
        end
        S_M03L: begin
          fbq   <= prod[spd_pkg::RECIP_SHIFT +: QW];
          state <= S_M03R;
        end
        S_M03R: begin
          fl    <= sat_res;
          state <= S_MWL;
        end
        S_MWL: begin
          fr    <= sat_res;
          state <= S_MWR;
        end
        S_MWR: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_data.delay_left        <= dl;
            out_data.delay_right       <= dr;
            out_data.reverb_feed_left  <= fl;
            out_data.reverb_feed_right <= fr;
            if (write_position == LAST_POS) begin
              write_position <= '0;
              wrapped        <= 1'b1;
            end else begin
              write_position <= write_position + AW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/spd_checker.sv
module spd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_we,
  input logic [spd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input logic [spd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input logic                                in_valid,
  input logic                                in_ready,
  input spd_pkg::in_item_t                   in_data,
  input logic                                out_valid,
  input logic                                out_ready,
  input spd_pkg::out_item_t                  out_data
);

  // Reset leaves the block empty and ready for a beat.
  a_reset_state: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // An accepted beat keeps the sequencer busy, so the input is not taken back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted again too soon");

  // A result only appears at the end of a busy period.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind stereo_ping_pong_delay spd_checker u_spd_checker (.*);

>>> tb/stereo_ping_pong_delay_tb.sv
module stereo_ping_pong_delay_tb;
  import spd_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int RANDOM_BEATS = 850;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int LIMIT_CYCLES = 1000000;

  // Tracks both delay lines and the intensity smoother, and keeps the results due.
  class ping_pong_scoreboard;
    bit signed [SAMPLE_BITS-1:0] left_line [DELAY_DEPTH];
    bit signed [SAMPLE_BITS-1:0] right_line [DELAY_DEPTH];
    bit [DELAY_BITS-1:0]     wr_pos;
    bit [31:0]               gain;
    longint                  gain_step;
    int unsigned             ramp_left;
    bit [INTENSITY_BITS-1:0] ramp_target;
    bit [INTENSITY_BITS-1:0] intensity_reg;
    bit [DELAY_BITS-1:0]     left_len;
    bit [DELAY_BITS-1:0]     right_len;
    bit [RAMP_BITS-1:0]      ramp_len;
    out_item_t               due_results[$];
    int                      mismatch_count;

    function new();
      wr_pos        = '0;
      gain          = '0;
      gain_step     = 0;
      ramp_left     = 0;
      ramp_target   = INTENSITY_RESET;
      intensity_reg = INTENSITY_RESET;
      left_len      = LEFT_DELAY_RESET;
      right_len     = RIGHT_DELAY_RESET;
      ramp_len      = RAMP_RESET;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        REG_INTENSITY:   intensity_reg = value[INTENSITY_BITS-1:0];
        REG_LEFT_DELAY:  left_len      = value[DELAY_BITS-1:0];
        REG_RIGHT_DELAY: right_len     = value[DELAY_BITS-1:0];
        REG_RAMP:        ramp_len      = value[RAMP_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // A new clamped target restarts the ramp; the last ramp step lands exactly on it.
    function void advance_gain();
      bit [INTENSITY_BITS-1:0] t;
      longint full;
      t = (intensity_reg > FULL_INTENSITY) ? FULL_INTENSITY : intensity_reg;
      full = longint'(t) << FRAC_BITS;
      if (t != ramp_target) begin
        ramp_target = t;
        if (ramp_len == 0) begin
          gain      = 32'(full);
          ramp_left = 0;
          gain_step = 0;
        end else begin
          ramp_left = ramp_len;
          gain_step = (full - longint'(gain)) / longint'(ramp_len);
        end
      end
      if (ramp_left > 0) begin
        ramp_left--;
        if (ramp_left > 0) gain = 32'(longint'(gain) + gain_step);
        else gain = 32'(longint'(ramp_target) << FRAC_BITS);
      end
    endfunction

    function longint scale_q24(longint x, longint c);
      return (x * c + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function longint saturate(longint x);
      longint hi;
      hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    function void note_sample_pair(in_item_t beat);
      longint in_l, in_r, dl, dr, fbq, fl, fr;
      bit [DELAY_BITS-1:0] left_tap, right_tap;
      out_item_t due;
      advance_gain();
      fbq = (longint'(gain) * 3) / 400;
      in_l = $signed(beat.sample_left);
      in_r = $signed(beat.sample_right);
      // Taps wrap with the write position; a length of zero reads the oldest entry.
      left_tap  = wr_pos - left_len;
      right_tap = wr_pos - right_len;
      dl = left_line[left_tap];
      dr = right_line[right_tap];
      fl = saturate(in_l + scale_q24(dl, COEF_POINT3));
      fr = saturate(in_r + scale_q24(dr, COEF_POINT3));
      left_line[wr_pos]  = SAMPLE_BITS'(saturate(in_l + scale_q24(dr, fbq)));
      right_line[wr_pos] = SAMPLE_BITS'(saturate(in_r + scale_q24(dl, fbq)));
      wr_pos = wr_pos + 1'b1;
      due.delay_left        = dl[SAMPLE_BITS-1:0];
      due.delay_right       = dr[SAMPLE_BITS-1:0];
      due.reverb_feed_left  = fl[SAMPLE_BITS-1:0];
      due.reverb_feed_right = fr[SAMPLE_BITS-1:0];
      due_results.push_back(due);
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 20) $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, logic signed [SAMPLE_BITS-1:0] got,
                       logic signed [SAMPLE_BITS-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    task check_result(out_item_t beat);
      out_item_t due;
      if (due_results.size() == 0) begin
        report_mismatch("output beat with no input beat to account for it");
        return;
      end
      due = due_results.pop_front();
      compare_field("delay_left", beat.delay_left, due.delay_left);
      compare_field("delay_right", beat.delay_right, due.delay_right);
      compare_field("reverb_feed_left", beat.reverb_feed_left, due.reverb_feed_left);
      compare_field("reverb_feed_right", beat.reverb_feed_right, due.reverb_feed_right);
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_ready;
  out_item_t                 out_data;

  ping_pong_scoreboard sb = new();
  int hold_requests = 0;

  stereo_ping_pong_delay DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] l, r);
    in_item_t beat;
    beat.sample_left  = l;
    beat.sample_right = r;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sb.note_sample_pair(beat);
  endtask

  // Only called with a nonzero gap.
  task automatic pause_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  // Unused upper data bits are randomized; the block must ignore them.
  task automatic apply_config(int intensity, int left_len, int right_len, int ramp);
    write_reg(REG_INTENSITY, {9'($urandom), 7'(intensity)});
    write_reg(REG_LEFT_DELAY, {1'($urandom), 15'(left_len)});
    write_reg(REG_RIGHT_DELAY, {1'($urandom), 15'(right_len)});
    write_reg(REG_RAMP, 16'(ramp));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic int random_delay();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32767;
      2: return $urandom_range(1, 400);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Receiver: alternating ready and stall runs, plus long hold-offs on request.
  initial begin
    int hold_left, run_left, holds_taken;
    bit take;
    hold_left = 0;
    run_left = 0;
    holds_taken = 0;
    take = 1'b1;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          take = ($urandom_range(0, 3) != 0);
          run_left = take ? $urandom_range(1, 40) : $urandom_range(1, 8);
        end
        run_left--;
        out_ready <= take;
      end
    end
  end

  initial begin
    int sent, remaining, burst, phase, intensity, ramp;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_INTENSITY;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Settings from reset: long delays, so the taps still read silence.
    send_item(0, 0);
    send_item(SAMPLE_MAX, SAMPLE_MIN);
    send_item(SAMPLE_MIN, SAMPLE_MAX);
    wait_for_drain();

    // Intensity above full scale with no ramp: full feedback at once, short taps.
    apply_config(127, 1, 2, 0);
    send_item(SAMPLE_MAX, SAMPLE_MAX);
    send_item(SAMPLE_MAX, SAMPLE_MIN);
    send_item(SAMPLE_MIN, SAMPLE_MIN);
    send_item(SAMPLE_MIN, SAMPLE_MAX);
    send_item(0, 0);
    send_item(-1, 1);
    send_item(1, -1);
    send_item(SAMPLE_MAX, SAMPLE_MAX);
    send_item(SAMPLE_MAX, SAMPLE_MAX);
    send_item(SAMPLE_MIN, SAMPLE_MIN);
    send_item(SAMPLE_MIN, SAMPLE_MIN);
    send_item(0, 0);
    wait_for_drain();

    // Zero-length and longest delays, one-step ramp down to zero.
    apply_config(0, 0, 32767, 1);
    send_item(SAMPLE_MAX, SAMPLE_MIN);
    send_item(SAMPLE_MIN, SAMPLE_MAX);
    send_item(-1, -1);
    send_item(SAMPLE_MAX, SAMPLE_MAX);
    wait_for_drain();

    // Short ramp up to exactly full intensity.
    apply_config(100, 3, 1, 5);
    send_item(SAMPLE_MAX, SAMPLE_MIN);
    send_item(SAMPLE_MIN, SAMPLE_MAX);
    send_item(SAMPLE_MAX, SAMPLE_MAX);
    send_item(12345, -54321);
    send_item(SAMPLE_MIN, SAMPLE_MIN);
    send_item(0, 0);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      wait_for_drain();
      case ($urandom_range(0, 5))
        0: intensity = 0;
        1: intensity = 100;
        2: intensity = 127;
        default: intensity = $urandom_range(0, 127);
      endcase
      case ($urandom_range(0, 7))
        0: ramp = 0;
        1: ramp = 65535;
        2: ramp = $urandom_range(1, 200);
        default: ramp = $urandom_range(1, 30);
      endcase
      apply_config(intensity, random_delay(), random_delay(), ramp);
      remaining = $urandom_range(30, 80);
      if (phase == 2) begin
        // The receiver holds off while beats keep coming, so the input backs up.
        hold_requests++;
        repeat (24) send_item(random_sample(), random_sample());
        sent += 24;
      end
      while (remaining > 0) begin
        burst = $urandom_range(1, 16);
        while (burst > 0 && remaining > 0) begin
          send_item(random_sample(), random_sample());
          burst--;
          remaining--;
          sent++;
        end
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 12));
      end
      phase++;
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Mismatches found");
    $finish;
  end

endmodule
